@@ sv/bas_pkg.sv @@
// Shared types and constants for the button axis slew smoother.
// Operation codes, register map and reset values. No dependencies.
package bas_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;

  typedef logic [1:0] op_t;
  localparam op_t OP_EVENT = 2'd0;
  localparam op_t OP_TICK  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_POS_CODE   = 3'd0;
  localparam reg_idx_t REG_NEG_CODE   = 3'd1;
  localparam reg_idx_t REG_RETURN     = 3'd2;
  localparam reg_idx_t REG_PRESS      = 3'd3;
  localparam reg_idx_t REG_DEAD_ZONE  = 3'd4;
  localparam reg_idx_t REG_SNAP       = 3'd5;
  localparam reg_idx_t REG_INVERT     = 3'd6;

  localparam logic [9:0]  RST_CODE      = 10'd1023;
  localparam logic [15:0] RST_RATE      = 16'd768;
  localparam logic [14:0] RST_DEAD_ZONE = 15'd16;

  // step saturates at 2.0 in Q2.14
  localparam logic [16:0] STEP_MAX = 17'd32768;

endpackage

@@ sv/button_axis_slew_smoother.sv @@
// Button axis slew smoother: two-button virtual axis with slew limiting and dead zone.
// An accepted word is held in the input register; its result word is then written to
// the output register, from which the receiver takes it.
// Throughput: one word per cycle unless out_tready stalls the output; a 16x16 multiply
// and an add/clamp sit between the input register and the output register.
// Reset (rst_n low, synchronous): pipeline empty, axis state zero, registers to defaults.
module button_axis_slew_smoother
  import bas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // button_code[8:0], pressed[9], dt[25:10], zero pad
  input  logic [1:0]       in_tuser,   // op[1:0]
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // raw_value[15:0], smoothed_value[31:16]
  // configuration
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  output logic [DataW-1:0] cfg_prdata,
  output logic             cfg_pready
);

  // configuration registers
  logic [9:0]  pos_code_r, neg_code_r;
  logic [15:0] return_rate_r, press_rate_r;
  logic [14:0] dead_zone_r;
  logic        snap_en_r, invert_en_r;

  // axis state
  logic signed [1:0]  raw_r,    raw_nxt;
  logic signed [15:0] smooth_r, smooth_nxt;

  // input register
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [8:0]  s1_code_r;
  logic        s1_pressed_r;
  logic [15:0] s1_dt_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;

  logic out_free, s1_fire, in_fire, cfg_wr;
  reg_idx_t cfg_idx;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_POS_CODE:  cfg_prdata = {22'd0, pos_code_r};
      REG_NEG_CODE:  cfg_prdata = {22'd0, neg_code_r};
      REG_RETURN:    cfg_prdata = {16'd0, return_rate_r};
      REG_PRESS:     cfg_prdata = {16'd0, press_rate_r};
      REG_DEAD_ZONE: cfg_prdata = {17'd0, dead_zone_r};
      REG_SNAP:      cfg_prdata = {31'd0, snap_en_r};
      REG_INVERT:    cfg_prdata = {31'd0, invert_en_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_code_r    <= RST_CODE;
      neg_code_r    <= RST_CODE;
      return_rate_r <= RST_RATE;
      press_rate_r  <= RST_RATE;
      dead_zone_r   <= RST_DEAD_ZONE;
      snap_en_r     <= 1'b1;
      invert_en_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POS_CODE:  pos_code_r    <= cfg_pwdata[9:0];
        REG_NEG_CODE:  neg_code_r    <= cfg_pwdata[9:0];
        REG_RETURN:    return_rate_r <= cfg_pwdata[15:0];
        REG_PRESS:     press_rate_r  <= cfg_pwdata[15:0];
        REG_DEAD_ZONE: dead_zone_r   <= cfg_pwdata[14:0];
        REG_SNAP:      snap_en_r     <= cfg_pwdata[0];
        REG_INVERT:    invert_en_r   <= cfg_pwdata[0];
        default:       ;
      endcase
    end
  end

  // ---- button event ----
  logic signed [2:0] ev_sum, ev_pos, ev_neg;
  logic signed [1:0] ev_level;

  always_comb begin
    ev_pos = '0;
    ev_neg = '0;
    if ({1'b0, s1_code_r} == pos_code_r) ev_pos = s1_pressed_r ? 3'sd1 : -3'sd1;
    if ({1'b0, s1_code_r} == neg_code_r) ev_neg = s1_pressed_r ? -3'sd1 : 3'sd1;
    ev_sum = 3'(ev_pos + ev_neg + 3'(raw_r));
    if (ev_sum > 3'sd1)       ev_level = 2'sd1;
    else if (ev_sum < -3'sd1) ev_level = -2'sd1;
    else                      ev_level = ev_sum[1:0];
  end

  // ---- tick ----
  logic [15:0]        rate_sel;
  logic [31:0]        prod;
  logic [16:0]        step;
  logic signed [17:0] target, s_cur, s_base, s_up, s_dn, s_mv, s_abs, dz_ext;
  logic               snap, up;
  logic signed [15:0] tick_level;

  always_comb begin
    rate_sel = (raw_r == 2'sd0) ? return_rate_r : press_rate_r;
    prod     = {16'd0, rate_sel} * {16'd0, s1_dt_r};
    step     = (prod[31:10] > 22'(STEP_MAX)) ? STEP_MAX : prod[26:10];
    target   = $signed({{2{raw_r[1]}}, raw_r, 14'd0});
    s_cur    = 18'(smooth_r);
    snap     = snap_en_r && ((target > 0 && s_cur < 0) || (target < 0 && s_cur > 0));
    s_base   = snap ? 18'sd0 : s_cur;
    up       = target > s_base;
    s_up     = s_base + $signed({1'b0, step});
    s_dn     = s_base - $signed({1'b0, step});
    if (up) s_mv = (s_up > target) ? target : s_up;
    else    s_mv = (s_dn < target) ? target : s_dn;
    s_abs    = (s_mv < 0) ? -s_mv : s_mv;
    dz_ext   = $signed({3'd0, dead_zone_r});
    tick_level = (s_abs < dz_ext) ? 16'sd0 : s_mv[15:0];
  end

  // ---- state update and result ----
  logic [15:0] raw_q14, raw_out, smooth_out;

  always_comb begin
    raw_nxt    = raw_r;
    smooth_nxt = smooth_r;
    unique case (s1_op_r)
      OP_EVENT: raw_nxt = ev_level;
      OP_TICK:  smooth_nxt = tick_level;
      OP_CLEAR: begin
        raw_nxt    = '0;
        smooth_nxt = '0;
      end
      default: ;
    endcase
    raw_q14      = {raw_nxt, 14'd0};
    raw_out      = invert_en_r ? 16'(-raw_q14) : raw_q14;
    smooth_out   = invert_en_r ? 16'(-smooth_nxt) : smooth_nxt;
    out_data_nxt = {smooth_out, raw_out};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      raw_r       <= '0;
      smooth_r    <= '0;
    end else begin
      if (in_fire) s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        raw_r       <= raw_nxt;
        smooth_r    <= smooth_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= in_tuser;
      s1_code_r    <= in_tdata[8:0];
      s1_pressed_r <= in_tdata[9];
      s1_dt_r      <= in_tdata[25:10];
    end
    if (s1_fire) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- checks ----
  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    raw_r != -2'sd2)
    else $error("raw level out of range");

  a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
    smooth_r <= 16'sd16384 && smooth_r >= -16'sd16384)
    else $error("smoothed level out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_op_r == OP_CLEAR |=> raw_r == 2'sd0 && smooth_r == 16'sd0)
    else $error("clear did not zero state");

  a_dead_zone: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_op_r == OP_TICK |=>
      smooth_r == 16'sd0 || smooth_r >= $signed({1'b0, dead_zone_r})
      || smooth_r <= -$signed({1'b0, dead_zone_r}))
    else $error("smoothed value inside dead zone after tick");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for button_axis_slew_smoother: streams event, tick, clear and unused-op
// words, predicts raw and smoothed axis values, checks each result word and reads back the registers.
// Depends on bas_pkg and the block's RTL.
module tb_top
  import bas_pkg::*;
;

  localparam op_t OP_NONE = 2'd3;  // unused op code: state stays, current values reported
  localparam int  UNIT    = 16384; // 1.0 in Q2.14

  class axis_tracker;
    logic [9:0]  pos_code, neg_code;
    logic [15:0] ret_rate, prs_rate;
    logic [14:0] dead_zone;
    logic        snap, invert;
    int          raw_lvl, smooth;
    logic [31:0] axis_q[$];
    int          n_bad;

    function new();
      n_bad     = 0;
      pos_code  = RST_CODE;
      neg_code  = RST_CODE;
      ret_rate  = RST_RATE;
      prs_rate  = RST_RATE;
      dead_zone = RST_DEAD_ZONE;
      snap      = 1'b1;
      invert    = 1'b0;
      raw_lvl   = 0;
      smooth    = 0;
    endfunction

    function void flag(string what, int want, int got);
      n_bad++;
      if (n_bad <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      unique case (idx)
        REG_POS_CODE:  pos_code  = v[9:0];
        REG_NEG_CODE:  neg_code  = v[9:0];
        REG_RETURN:    ret_rate  = v[15:0];
        REG_PRESS:     prs_rate  = v[15:0];
        REG_DEAD_ZONE: dead_zone = v[14:0];
        REG_SNAP:      snap      = v[0];
        REG_INVERT:    invert    = v[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(reg_idx_t idx);
      unique case (idx)
        REG_POS_CODE:  return {22'd0, pos_code};
        REG_NEG_CODE:  return {22'd0, neg_code};
        REG_RETURN:    return {16'd0, ret_rate};
        REG_PRESS:     return {16'd0, prs_rate};
        REG_DEAD_ZONE: return {17'd0, dead_zone};
        REG_SNAP:      return {31'd0, snap};
        REG_INVERT:    return {31'd0, invert};
        default:       return 32'd0;
      endcase
    endfunction

    function void press_event(logic [8:0] code, logic pressed);
      int v;
      v = raw_lvl;
      // codes of 512 and up never match a 9-bit button code
      if ({1'b0, code} == pos_code) v += pressed ? 1 : -1;
      if ({1'b0, code} == neg_code) v += pressed ? -1 : 1;
      if (v > 1) v = 1;
      if (v < -1) v = -1;
      raw_lvl = v;
    endfunction

    function void slew_tick(logic [15:0] dt);
      int          target, s, step, dz;
      int unsigned rate, prod;
      target = raw_lvl * UNIT;
      s      = smooth;
      rate   = (raw_lvl == 0) ? ret_rate : prs_rate;
      prod   = (rate * dt) >> 10;  // Q8.24 product down to Q2.14
      step   = (prod > STEP_MAX) ? STEP_MAX : prod;
      dz     = dead_zone;
      if (snap && ((target > 0 && s < 0) || (target < 0 && s > 0))) s = 0;
      if (target > s) begin
        s += step;
        if (s > target) s = target;
      end else begin
        s -= step;
        if (s < target) s = target;
      end
      if (-dz < s && s < dz) s = 0;
      smooth = s;
    endfunction

    function void note_word(op_t op, logic [8:0] code, logic pressed, logic [15:0] dt);
      int r, s;
      unique case (op)
        OP_EVENT: press_event(code, pressed);
        OP_TICK:  slew_tick(dt);
        OP_CLEAR: begin
          raw_lvl = 0;
          smooth  = 0;
        end
        default: ;
      endcase
      r = raw_lvl * UNIT;
      s = smooth;
      if (invert) begin
        r = -r;
        s = -s;
      end
      axis_q.push_back({s[15:0], r[15:0]});
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      if (axis_q.size() == 0) begin
        flag("result word with none outstanding", 0, got);
        return;
      end
      want = axis_q.pop_front();
      if (got[15:0] !== want[15:0])
        flag("raw_value", $signed(want[15:0]), $signed(got[15:0]));
      if (got[31:16] !== want[31:16])
        flag("smoothed_value", $signed(want[31:16]), $signed(got[31:16]));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [31:0]      in_tdata;   // button_code[8:0], pressed[9], dt[25:10], zero pad
  logic [1:0]       in_tuser;   // op[1:0]
  logic             out_tvalid;
  logic             out_tready;
  logic [31:0]      out_tdata;  // raw_value[15:0], smoothed_value[31:16]
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [DataW-1:0] cfg_pwdata;
  logic [DataW-1:0] cfg_prdata;
  logic             cfg_pready;

  axis_tracker sb;
  bit          tx_calm;
  bit          rx_calm;
  int          hold_cycles;

  button_axis_slew_smoother u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // all tasks are entered and left at a falling edge
  task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check(reg_idx_t idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== sb.reg_value(idx))
      sb.flag("register readback", sb.reg_value(idx), cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_word(op_t op, logic [8:0] code, logic pressed, logic [15:0] dt);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, dt, pressed, code};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, code, pressed, dt);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding word come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.axis_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic rand_word();
    int          pick;
    op_t         op;
    logic [8:0]  code;
    logic        pressed;
    logic [15:0] dt;
    pick    = $urandom_range(0, 99);
    code    = 9'($urandom_range(0, 511));
    pressed = 1'($urandom_range(0, 1));
    dt      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    op      = OP_EVENT;
    if (pick < 24) begin
      if (sb.pos_code < 512) code = sb.pos_code[8:0];
    end else if (pick < 46) begin
      if (sb.neg_code < 512) code = sb.neg_code[8:0];
    end else if (pick < 82) begin
      op = OP_TICK;
    end else if (pick < 90) begin
      op = OP_EVENT;  // stray button code
    end else if (pick < 95) begin
      op = OP_CLEAR;
    end else begin
      op = OP_NONE;
    end
    send_word(op, code, pressed, dt);
  endtask

  task automatic set_phase(int p);
    logic [31:0] v [7];
    v[0] = ($urandom_range(0, 7) == 0) ? 32'd1023 : $urandom_range(0, 511);
    v[1] = ($urandom_range(0, 7) == 0) ? 32'd1023 : $urandom_range(0, 511);
    v[2] = $urandom_range(0, 65535);
    v[3] = $urandom_range(0, 65535);
    v[4] = $urandom_range(0, 16384);
    v[5] = $urandom_range(0, 1);
    v[6] = $urandom_range(0, 1);
    unique case (p)
      1: v = '{17, 42, 768, 768, 16, 1, 0};
      2: v = '{511, 0, 0, 65535, 16384, 0, 1};
      3: v = '{200, 200, 65535, 0, 100, 1, 1};  // equal codes cancel
      4: begin
        v[0] = 1023;
        v[1] = 3;
        v[4] = 0;
        v[5] = 0;
      end
      5: begin
        v[0] = 512;
        v[1] = 1023;
      end
      default: ;
    endcase
    for (int i = 0; i <= REG_INVERT; i++) cfg_write(reg_idx_t'(i), v[i]);
    for (int i = 0; i <= REG_INVERT; i++) cfg_check(reg_idx_t'(i));
  endtask

  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) stall = hold_cycles;
      else stall = rx_calm ? 0 : $urandom_range(0, 8);
      hold_cycles = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_word(out_tdata);
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_EVENT;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    hold_cycles = 0;
    sb          = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i <= REG_INVERT; i++) cfg_check(reg_idx_t'(i));

    // directed: positive on code 0, negative on code 511, default rates
    cfg_write(REG_POS_CODE, 32'd0);
    cfg_write(REG_NEG_CODE, 32'd511);
    send_word(OP_TICK,  9'h1FF, 1'b1, 16'hFFFF);  // target already reached at zero
    send_word(OP_EVENT, 9'h000, 1'b1, 16'hFFFF);
    send_word(OP_TICK,  9'h000, 1'b0, 16'h0000);
    send_word(OP_TICK,  9'h000, 1'b0, 16'h0005);  // tiny step lands in dead zone
    send_word(OP_TICK,  9'h000, 1'b0, 16'h1000);
    send_word(OP_TICK,  9'h000, 1'b0, 16'hFFFF);  // saturated step, stops at target
    send_word(OP_TICK,  9'h155, 1'b1, 16'h5555);
    send_word(OP_EVENT, 9'h1FF, 1'b1, 16'h0000);  // raw back to zero
    send_word(OP_TICK,  9'h000, 1'b0, 16'h0800);  // return rate
    send_word(OP_EVENT, 9'h000, 1'b0, 16'h0000);  // raw -1
    send_word(OP_TICK,  9'h000, 1'b0, 16'h2AAA);  // snap on sign reversal
    send_word(OP_EVENT, 9'h1FF, 1'b1, 16'h0000);  // clamp at -1
    send_word(OP_EVENT, 9'h0AA, 1'b1, 16'h0000);  // unmapped code
    send_word(OP_NONE,  9'h000, 1'b1, 16'hFFFF);
    send_word(OP_CLEAR, 9'h1FF, 1'b1, 16'hFFFF);
    send_word(OP_EVENT, 9'h1FF, 1'b0, 16'h0000);
    send_word(OP_TICK,  9'h000, 1'b0, 16'hAAAA);
    send_word(OP_EVENT, 9'h155, 1'b0, 16'h0000);
    send_word(OP_EVENT, 9'h000, 1'b1, 16'h0000);  // clamp at +1
    send_word(OP_CLEAR, 9'h000, 1'b0, 16'h0000);
    drain();
    cfg_write(REG_INVERT, 32'd1);
    send_word(OP_EVENT, 9'h000, 1'b1, 16'h0000);
    send_word(OP_TICK,  9'h000, 1'b0, 16'hFFFF);
    drain();

    for (int p = 1; p <= 7; p++) begin
      set_phase(p);
      tx_calm = (p == 3) || (p == 6);
      rx_calm = (p == 4) || (p == 6);
      for (int k = 0; k < 125; k++) begin
        if (p == 2 && k == 40) hold_cycles = 80;  // long receiver hold-off, input backs up
        if (p == 5 && k == 60) drain();
        rand_word();
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (sb.n_bad == 0 && sb.axis_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
